// ===== rtl/plti_pkg.sv =====
// Shared types and constants for the piecewise-linear polar table interpolator.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package plti_pkg;

    localparam int MAX_POINTS = 32;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int CFG_W    = 6;
    localparam int IDX_W    = 5;
    localparam int ANGLE_W  = 24;
    localparam int COEF_W   = 16;
    localparam int REGION_W = 2;

    // interpolation datapath widths
    localparam int DY_W   = COEF_W + 1;
    localparam int Q_BITS = DY_W;                  // |quotient| < |dy|
    localparam int PROD_W = ANGLE_W + 1 + DY_W;
    localparam int MAG_W  = PROD_W - 1;
    localparam int SUM_W  = Q_BITS + 1;
    localparam int STEP_W = $clog2(Q_BITS);

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_QUERY,
        OP_DROP
    } op_t;

    typedef enum logic [REGION_W-1:0] {
        REGION_BELOW  = 2'd0,
        REGION_INTERP = 2'd1,
        REGION_LAST   = 2'd2,
        REGION_EMPTY  = 2'd3
    } region_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  entry_index;
        logic [ANGLE_W-1:0] angle;
        logic [COEF_W-1:0] lift_coef;
        logic [COEF_W-1:0] drag_coef;
    } item_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [COEF_W-1:0]  lift;
        logic [COEF_W-1:0]  drag;
    } entry_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] dx;       // x - a_i, never negative
        logic [ANGLE_W-1:0] span;     // a_i+1 - a_i, always positive
        logic [DY_W-1:0]    dy_lift;
        logic [DY_W-1:0]    dy_drag;
        logic [COEF_W-1:0]  y0_lift;
        logic [COEF_W-1:0]  y0_drag;
    } interp_req_t;

    typedef struct packed {
        logic [COEF_W-1:0] lift;
        logic [COEF_W-1:0] drag;
    } interp_rsp_t;

endpackage

// ===== rtl/plti_front.sv =====
// Input side: accepts beats, classifies them into write/query/drop commands
// and holds them in a small FIFO for the back end. Uses plti_pkg.
module plti_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [plti_pkg::IDX_W-1:0]   s_entry_index,
    input  logic [plti_pkg::ANGLE_W-1:0] s_angle,
    input  logic [plti_pkg::COEF_W-1:0]  s_lift_coef,
    input  logic [plti_pkg::COEF_W-1:0]  s_drag_coef,
    output logic                         q_valid,
    output plti_pkg::item_t              q_item,
    input  logic                         q_pop
);

    plti_pkg::item_t                  queue_reg [plti_pkg::QDEPTH];
    logic [plti_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [plti_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [plti_pkg::QCNT_W-1:0]      count_reg, count_next;
    plti_pkg::item_t                  item;
    logic                             push;
    logic                             pop;

    assign s_ready = (count_reg != plti_pkg::QCNT_W'(plti_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = queue_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        item.entry_index = s_entry_index;
        item.angle       = s_angle;
        item.lift_coef   = s_lift_coef;
        item.drag_coef   = s_drag_coef;
        if (s_func == plti_pkg::FUNC_QUERY) begin
            item.op = plti_pkg::OP_QUERY;
        end else if (int'(s_entry_index) < plti_pkg::MAX_POINTS) begin
            item.op = plti_pkg::OP_WRITE;
        end else begin
            item.op = plti_pkg::OP_DROP;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + plti_pkg::QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + plti_pkg::QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + plti_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - plti_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ===== rtl/plti_interp.sv =====
// Two-lane interpolation unit: one multiply, then a restoring divide that retires
// one quotient bit per cycle, then add and saturate. Uses plti_pkg.
module plti_interp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  plti_pkg::interp_req_t req,
    output logic                  done,
    output plti_pkg::interp_rsp_t rsp
);

    localparam int NLANE = 2;   // lane 0 lift, lane 1 drag

    typedef enum logic [2:0] {
        P_IDLE,
        P_ABS,
        P_DIV,
        P_FIN
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [plti_pkg::STEP_W-1:0]         step_reg, step_next;
    logic                                done_reg, done_next;
    plti_pkg::interp_rsp_t               rsp_reg, rsp_next;

    logic signed [plti_pkg::PROD_W-1:0]  prod_reg [NLANE];
    logic signed [plti_pkg::PROD_W-1:0]  prod_next [NLANE];
    logic        [plti_pkg::ANGLE_W-1:0] rem_reg [NLANE];
    logic        [plti_pkg::ANGLE_W-1:0] rem_next [NLANE];
    logic        [plti_pkg::Q_BITS-1:0]  quot_reg [NLANE];
    logic        [plti_pkg::Q_BITS-1:0]  quot_next [NLANE];
    logic                                neg_reg [NLANE];
    logic                                neg_next [NLANE];

    logic signed [plti_pkg::DY_W-1:0]    dy [NLANE];
    logic        [plti_pkg::COEF_W-1:0]  y0 [NLANE];
    logic        [plti_pkg::COEF_W-1:0]  res [NLANE];
    logic        [plti_pkg::PROD_W-1:0]  neg_prod [NLANE];
    logic        [plti_pkg::MAG_W-1:0]   mag [NLANE];
    logic        [plti_pkg::ANGLE_W:0]   trial [NLANE];
    logic        [plti_pkg::ANGLE_W:0]   diff [NLANE];
    logic        [plti_pkg::SUM_W-1:0]   qval [NLANE];
    logic        [plti_pkg::SUM_W-1:0]   sum [NLANE];
    logic [plti_pkg::SUM_W-plti_pkg::COEF_W:0] sum_top [NLANE];

    assign dy[0] = $signed(req.dy_lift);
    assign dy[1] = $signed(req.dy_drag);
    assign y0[0] = req.y0_lift;
    assign y0[1] = req.y0_drag;

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // lane datapaths, all independent
    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            prod_next[l] = $signed({1'b0, req.dx}) * dy[l];
            neg_prod[l]  = -prod_reg[l];
            mag[l]       = prod_reg[l][plti_pkg::PROD_W-1] ?
                           neg_prod[l][plti_pkg::MAG_W-1:0] :
                           prod_reg[l][plti_pkg::MAG_W-1:0];
            trial[l]     = {rem_reg[l], quot_reg[l][plti_pkg::Q_BITS-1]};
            diff[l]      = trial[l] - {1'b0, req.span};
            qval[l]      = {1'b0, quot_reg[l]};
            sum[l]       = {{(plti_pkg::SUM_W - plti_pkg::COEF_W){y0[l][plti_pkg::COEF_W-1]}},
                            y0[l]}
                         + (neg_reg[l] ? -qval[l] : qval[l]);
            sum_top[l]   = sum[l][plti_pkg::SUM_W-1:plti_pkg::COEF_W-1];
            if ((&sum_top[l]) || !(|sum_top[l])) begin
                res[l] = sum[l][plti_pkg::COEF_W-1:0];
            end else if (sum[l][plti_pkg::SUM_W-1]) begin
                res[l] = {1'b1, {(plti_pkg::COEF_W-1){1'b0}}};
            end else begin
                res[l] = {1'b0, {(plti_pkg::COEF_W-1){1'b1}}};
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        for (int l = 0; l < NLANE; l++) begin
            rem_next[l]  = rem_reg[l];
            quot_next[l] = quot_reg[l];
            neg_next[l]  = neg_reg[l];
        end
        unique case (phase_reg)
            P_IDLE: begin
                if (start) begin
                    phase_next = P_ABS;
                end
            end
            P_ABS: begin
                // |dx*dy| < span * 2^Q_BITS, so the top part is already below span
                for (int l = 0; l < NLANE; l++) begin
                    neg_next[l]  = prod_reg[l][plti_pkg::PROD_W-1];
                    rem_next[l]  = mag[l][plti_pkg::MAG_W-1:plti_pkg::Q_BITS];
                    quot_next[l] = mag[l][plti_pkg::Q_BITS-1:0];
                end
                step_next  = '0;
                phase_next = P_DIV;
            end
            P_DIV: begin
                for (int l = 0; l < NLANE; l++) begin
                    if (!diff[l][plti_pkg::ANGLE_W]) begin
                        rem_next[l] = diff[l][plti_pkg::ANGLE_W-1:0];
                    end else begin
                        rem_next[l] = trial[l][plti_pkg::ANGLE_W-1:0];
                    end
                    quot_next[l] = {quot_reg[l][plti_pkg::Q_BITS-2:0],
                                    !diff[l][plti_pkg::ANGLE_W]};
                end
                step_next = step_reg + plti_pkg::STEP_W'(1);
                if (step_reg == plti_pkg::STEP_W'(plti_pkg::Q_BITS - 1)) begin
                    phase_next = P_FIN;
                end
            end
            P_FIN: begin
                rsp_next.lift = res[0];
                rsp_next.drag = res[1];
                done_next     = 1'b1;
                phase_next    = P_IDLE;
            end
            default: begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        step_reg <= step_next;
        rsp_reg  <= rsp_next;
        for (int l = 0; l < NLANE; l++) begin
            if (phase_reg == P_IDLE) begin
                prod_reg[l] <= prod_next[l];
            end
            rem_reg[l]  <= rem_next[l];
            quot_reg[l] <= quot_next[l];
            neg_reg[l]  <= neg_next[l];
        end
    end

endmodule

// ===== rtl/plti_back.sv =====
// Execution side: owns the polar table memory, applies writes, walks the table
// for queries and drives the result register. Uses plti_pkg and plti_interp.
module plti_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [plti_pkg::CFG_W-1:0]    point_count,
    input  logic                          q_valid,
    input  plti_pkg::item_t               q_item,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [plti_pkg::COEF_W-1:0]   m_lift_result,
    output logic [plti_pkg::COEF_W-1:0]   m_drag_result,
    output logic [plti_pkg::REGION_W-1:0] m_region
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIRST,
        S_WALK,
        S_INTERP
    } state_t;

    plti_pkg::entry_t                mem [plti_pkg::MAX_POINTS];
    plti_pkg::entry_t                rd_data_reg;
    plti_pkg::entry_t                wr_data;
    logic [plti_pkg::ADDR_W-1:0]     rd_addr;
    logic [plti_pkg::ADDR_W-1:0]     wr_addr;
    logic                            mem_we;

    state_t                          state_reg, state_next;
    logic [plti_pkg::CNT_W-1:0]      k_reg, k_next;
    logic [plti_pkg::ANGLE_W-1:0]    x_reg, x_next;
    plti_pkg::entry_t                prev_reg, prev_next;
    plti_pkg::interp_req_t           req_reg, req_next;
    logic                            start_reg, start_next;
    logic                            out_valid_reg, out_valid_next;
    logic [plti_pkg::COEF_W-1:0]     lift_reg, lift_next;
    logic [plti_pkg::COEF_W-1:0]     drag_reg, drag_next;
    plti_pkg::region_t               region_reg, region_next;

    logic [plti_pkg::CNT_W-1:0]      len;
    logic [plti_pkg::CNT_W-1:0]      k_inc;
    logic                            slot_free;
    plti_pkg::entry_t                cur;
    logic                            ip_done;
    plti_pkg::interp_rsp_t           ip_rsp;

    plti_interp u_interp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .req     (req_reg),
        .done    (ip_done),
        .rsp     (ip_rsp)
    );

    assign m_valid       = out_valid_reg;
    assign m_lift_result = lift_reg;
    assign m_drag_result = drag_reg;
    assign m_region      = region_reg;

    assign cur       = rd_data_reg;
    assign k_inc     = k_reg + plti_pkg::CNT_W'(1);
    // only the engine fills the result register, so a query may start once it drains
    assign slot_free = !out_valid_reg || m_ready;

    assign wr_addr         = plti_pkg::ADDR_W'(q_item.entry_index);
    assign wr_data.angle   = q_item.angle;
    assign wr_data.lift    = q_item.lift_coef;
    assign wr_data.drag    = q_item.drag_coef;

    always_comb begin
        if (int'(point_count) > plti_pkg::MAX_POINTS) begin
            len = plti_pkg::CNT_W'(plti_pkg::MAX_POINTS);
        end else begin
            len = plti_pkg::CNT_W'(point_count);
        end
    end

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        x_next         = x_reg;
        prev_next      = prev_reg;
        req_next       = req_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg && !m_ready;
        lift_next      = lift_reg;
        drag_next      = drag_reg;
        region_next    = region_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        // prefetch the entry after the one under test
        rd_addr        = k_inc[plti_pkg::ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                rd_addr = '0;
                if (q_valid) begin
                    unique case (q_item.op)
                        plti_pkg::OP_WRITE: begin
                            q_pop  = 1'b1;
                            mem_we = 1'b1;
                        end
                        plti_pkg::OP_DROP: begin
                            q_pop = 1'b1;
                        end
                        plti_pkg::OP_QUERY: begin
                            if (slot_free) begin
                                q_pop  = 1'b1;
                                x_next = q_item.angle;
                                k_next = '0;
                                if (len == '0) begin
                                    out_valid_next = 1'b1;
                                    lift_next      = '0;
                                    drag_next      = '0;
                                    region_next    = plti_pkg::REGION_EMPTY;
                                end else begin
                                    state_next = S_FIRST;
                                end
                            end
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_FIRST: begin
                if ($signed(x_reg) < $signed(cur.angle)) begin
                    out_valid_next = 1'b1;
                    lift_next      = cur.lift;
                    drag_next      = cur.drag;
                    region_next    = plti_pkg::REGION_BELOW;
                    state_next     = S_IDLE;
                end else if (len == plti_pkg::CNT_W'(1)) begin
                    out_valid_next = 1'b1;
                    lift_next      = cur.lift;
                    drag_next      = cur.drag;
                    region_next    = plti_pkg::REGION_LAST;
                    state_next     = S_IDLE;
                end else begin
                    prev_next  = cur;
                    k_next     = k_inc;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                // prev holds entry k-1, cur holds entry k
                if ($signed(x_reg) >= $signed(prev_reg.angle) &&
                    $signed(x_reg) < $signed(cur.angle)) begin
                    req_next.dx      = x_reg - prev_reg.angle;
                    req_next.span    = cur.angle - prev_reg.angle;
                    req_next.dy_lift = {cur.lift[plti_pkg::COEF_W-1], cur.lift}
                                     - {prev_reg.lift[plti_pkg::COEF_W-1], prev_reg.lift};
                    req_next.dy_drag = {cur.drag[plti_pkg::COEF_W-1], cur.drag}
                                     - {prev_reg.drag[plti_pkg::COEF_W-1], prev_reg.drag};
                    req_next.y0_lift = prev_reg.lift;
                    req_next.y0_drag = prev_reg.drag;
                    start_next       = 1'b1;
                    state_next       = S_INTERP;
                end else if (k_inc == len) begin
                    out_valid_next = 1'b1;
                    lift_next      = cur.lift;
                    drag_next      = cur.drag;
                    region_next    = plti_pkg::REGION_LAST;
                    state_next     = S_IDLE;
                end else begin
                    prev_next = cur;
                    k_next    = k_inc;
                end
            end
            S_INTERP: begin
                if (ip_done) begin
                    out_valid_next = 1'b1;
                    lift_next      = ip_rsp.lift;
                    drag_next      = ip_rsp.drag;
                    region_next    = plti_pkg::REGION_INTERP;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
        k_reg      <= k_next;
        x_reg      <= x_next;
        prev_reg   <= prev_next;
        req_reg    <= req_next;
        lift_reg   <= lift_next;
        drag_reg   <= drag_next;
        region_reg <= region_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ===== rtl/piecewise_linear_table_interp.sv =====
// Piecewise-linear airfoil polar lookup: a table of (angle, lift, drag) entries
// that answers queries with linearly interpolated lift and drag coefficients.
// A write beat (func 0) stores one entry; a query beat (func 1) returns one
// result beat with lift, drag and a region code. Incoming beats land in a
// four-deep command queue, so the input side keeps accepting until the queue is full
// while the engine works or a result waits. The engine reads the table one entry
// per cycle while walking it. A query interpolated in an interval uses a multiply
// and the bit-serial 17-step divide. Table entries are not cleared by reset and
// must be written before a query reads them.
// Depends on plti_pkg, plti_front, plti_back.
module piecewise_linear_table_interp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [plti_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [plti_pkg::IDX_W-1:0]    s_entry_index,
    input  logic [plti_pkg::ANGLE_W-1:0]  s_angle,
    input  logic [plti_pkg::COEF_W-1:0]   s_lift_coef,
    input  logic [plti_pkg::COEF_W-1:0]   s_drag_coef,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [plti_pkg::COEF_W-1:0]   m_lift_result,
    output logic [plti_pkg::COEF_W-1:0]   m_drag_result,
    output logic [plti_pkg::REGION_W-1:0] m_region
);

    logic [plti_pkg::CFG_W-1:0] point_count_reg;
    logic                       q_valid;
    plti_pkg::item_t            q_item;
    logic                       q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= '0;
        end else if (cfg_wr_en) begin
            point_count_reg <= cfg_wr_data;
        end
    end

    plti_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_entry_index (s_entry_index),
        .s_angle       (s_angle),
        .s_lift_coef   (s_lift_coef),
        .s_drag_coef   (s_drag_coef),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    plti_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .point_count   (point_count_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_lift_result (m_lift_result),
        .m_drag_result (m_drag_result),
        .m_region      (m_region)
    );

endmodule
